// ===== rtl/i2c_seq_pkg.sv =====
// Package for the I2C master sequencer: item types, phase encoding and bus codes.
`timescale 1ns / 1ps
`default_nettype none

package i2c_seq_pkg;

   // request item commands
   localparam logic [1:0] CMD_BEGIN  = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_STATUS = 2'd2;

   // bus actions
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_START   = 3'd1;
   localparam logic [2:0] ACT_ADDR    = 3'd2;
   localparam logic [2:0] ACT_DATA    = 3'd3;
   localparam logic [2:0] ACT_RX_ACK  = 3'd4;
   localparam logic [2:0] ACT_RX_NACK = 3'd5;
   localparam logic [2:0] ACT_STOP    = 3'd6;

   // engine status codes, compared after masking
   localparam logic [7:0] STATUS_MASK     = 8'hF8;
   localparam logic [7:0] ST_REP_START    = 8'h10;
   localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
   localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
   localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
   localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
   localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

   // transaction phase
   typedef enum logic [3:0] {
      PH_IDLE          = 4'd0,
      PH_WAIT_START    = 4'd1,
      PH_WAIT_SLAW     = 4'd2,
      PH_WANT_DATA     = 4'd3,
      PH_WAIT_DATA     = 4'd4,
      PH_WAIT_REPSTART = 4'd5,
      PH_WAIT_SLAR     = 4'd6,
      PH_WAIT_RX_ACK   = 4'd7,
      PH_WAIT_RX_NACK  = 4'd8
   } phase_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] target_address;
      logic       with_read;
      logic [7:0] request_count;
      logic [7:0] response_count;
      logic [7:0] write_byte;
      logic [7:0] bus_status;
      logic [7:0] bus_read_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] bus_action;
      logic [7:0] bus_byte;
      logic       need_data;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       done_res;
      logic       failed;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/i2c_master_write_read_sequencer.sv =====
// Top level of the I2C master write/read transaction sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Sequences one I2C master transaction (start, address, write bytes, optional
// repeated start and reads, stop) one bus action per item. Every request item
// (begin, write byte or engine status event) yields exactly one response item;
// items that do not fit the current phase yield an all-zero response. Each
// item passes an input register and a result register; one item is taken every
// cycle unless the response side stalls. The phase and counter update, the only
// limit, finishes in the cycle an item leaves the input register.
// Status bytes are compared with their three low bits masked off.
module i2c_master_write_read_sequencer (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire i2c_seq_pkg::req_type req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output i2c_seq_pkg::rsp_type      rsp_data
);

   // pipeline registers
   logic                  in_valid_ff, in_valid_in;
   i2c_seq_pkg::req_type  in_item_ff, in_item_in;
   logic                  out_valid_ff, out_valid_in;
   i2c_seq_pkg::rsp_type  out_item_ff, out_item_in;

   // transaction state
   i2c_seq_pkg::phase_type phase_ff, phase_in;
   logic [3:0]             addr_hi_ff, addr_hi_in;
   logic                   read_wanted_ff, read_wanted_in;
   logic [7:0]             to_send_ff, to_send_in;
   logic [7:0]             to_read_ff, to_read_in;

   logic                   advance;
   logic [7:0]             status_m;
   logic [7:0]             read_dec;
   logic [7:0]             send_dec;
   i2c_seq_pkg::rsp_type   rsp_in;

   // handshake: item moves on when the result register is free or draining
   always_comb begin
      advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
      req_stall = in_valid_ff && !advance;
      rsp_valid = out_valid_ff;
      rsp_data  = out_item_ff;
   end

   // pipeline register next values
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_item_in = req_data;
         end
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_item_in  = rsp_in;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // sequencer: response and next state for the item in the input register
   always_comb begin
      status_m       = in_item_ff.bus_status & i2c_seq_pkg::STATUS_MASK;
      read_dec       = to_read_ff - 8'd1;
      send_dec       = to_send_ff - 8'd1;
      rsp_in         = '0;
      phase_in       = phase_ff;
      addr_hi_in     = addr_hi_ff;
      read_wanted_in = read_wanted_ff;
      to_send_in     = to_send_ff;
      to_read_in     = to_read_ff;

      case (in_item_ff.command)
         i2c_seq_pkg::CMD_BEGIN: begin
            if (phase_ff == i2c_seq_pkg::PH_IDLE) begin
               addr_hi_in        = in_item_ff.target_address[7:4];
               read_wanted_in    = in_item_ff.with_read;
               to_send_in        = in_item_ff.request_count;
               to_read_in        = (in_item_ff.response_count == 8'd0) ?
                                   8'd1 : in_item_ff.response_count;
               rsp_in.bus_action = i2c_seq_pkg::ACT_START;
               phase_in          = i2c_seq_pkg::PH_WAIT_START;
            end
         end
         i2c_seq_pkg::CMD_WRITE: begin
            if (phase_ff == i2c_seq_pkg::PH_WANT_DATA) begin
               rsp_in.bus_action = i2c_seq_pkg::ACT_DATA;
               rsp_in.bus_byte   = in_item_ff.write_byte;
               to_send_in        = send_dec;
               phase_in          = i2c_seq_pkg::PH_WAIT_DATA;
            end
         end
         i2c_seq_pkg::CMD_STATUS: begin
            case (phase_ff)
               i2c_seq_pkg::PH_WAIT_START: begin
                  // status after the first start is not checked
                  rsp_in.bus_action = i2c_seq_pkg::ACT_ADDR;
                  rsp_in.bus_byte   = {addr_hi_ff, 4'b0000};
                  phase_in          = i2c_seq_pkg::PH_WAIT_SLAW;
               end
               i2c_seq_pkg::PH_WAIT_SLAW, i2c_seq_pkg::PH_WAIT_DATA: begin
                  if ((phase_ff == i2c_seq_pkg::PH_WAIT_SLAW &&
                       status_m != i2c_seq_pkg::ST_MT_SLA_ACK) ||
                      (phase_ff == i2c_seq_pkg::PH_WAIT_DATA &&
                       status_m != i2c_seq_pkg::ST_MT_DATA_ACK)) begin
                     rsp_in.bus_action = i2c_seq_pkg::ACT_STOP;
                     rsp_in.done_res   = 1'b1;
                     rsp_in.failed     = 1'b1;
                     phase_in          = i2c_seq_pkg::PH_IDLE;
                  end else if (to_send_ff != 8'd0) begin
                     rsp_in.need_data = 1'b1;
                     phase_in         = i2c_seq_pkg::PH_WANT_DATA;
                  end else if (read_wanted_ff) begin
                     rsp_in.bus_action = i2c_seq_pkg::ACT_START;
                     phase_in          = i2c_seq_pkg::PH_WAIT_REPSTART;
                  end else begin
                     rsp_in.bus_action = i2c_seq_pkg::ACT_STOP;
                     rsp_in.done_res   = 1'b1;
                     phase_in          = i2c_seq_pkg::PH_IDLE;
                  end
               end
               i2c_seq_pkg::PH_WAIT_REPSTART: begin
                  if (status_m != i2c_seq_pkg::ST_REP_START) begin
                     rsp_in.bus_action = i2c_seq_pkg::ACT_STOP;
                     rsp_in.done_res   = 1'b1;
                     rsp_in.failed     = 1'b1;
                     phase_in          = i2c_seq_pkg::PH_IDLE;
                  end else begin
                     rsp_in.bus_action = i2c_seq_pkg::ACT_ADDR;
                     rsp_in.bus_byte   = {addr_hi_ff, 4'b0001};
                     phase_in          = i2c_seq_pkg::PH_WAIT_SLAR;
                  end
               end
               i2c_seq_pkg::PH_WAIT_SLAR: begin
                  if (status_m != i2c_seq_pkg::ST_MR_SLA_ACK) begin
                     rsp_in.bus_action = i2c_seq_pkg::ACT_STOP;
                     rsp_in.done_res   = 1'b1;
                     rsp_in.failed     = 1'b1;
                     phase_in          = i2c_seq_pkg::PH_IDLE;
                  end else if (to_read_ff > 8'd1) begin
                     rsp_in.bus_action = i2c_seq_pkg::ACT_RX_ACK;
                     phase_in          = i2c_seq_pkg::PH_WAIT_RX_ACK;
                  end else begin
                     rsp_in.bus_action = i2c_seq_pkg::ACT_RX_NACK;
                     phase_in          = i2c_seq_pkg::PH_WAIT_RX_NACK;
                  end
               end
               i2c_seq_pkg::PH_WAIT_RX_ACK: begin
                  // received byte is passed on even when the status is wrong
                  rsp_in.read_valid = 1'b1;
                  rsp_in.read_byte  = in_item_ff.bus_read_byte;
                  if (status_m != i2c_seq_pkg::ST_MR_DATA_ACK) begin
                     rsp_in.bus_action = i2c_seq_pkg::ACT_STOP;
                     rsp_in.done_res   = 1'b1;
                     rsp_in.failed     = 1'b1;
                     phase_in          = i2c_seq_pkg::PH_IDLE;
                  end else begin
                     to_read_in = read_dec;
                     if (read_dec > 8'd1) begin
                        rsp_in.bus_action = i2c_seq_pkg::ACT_RX_ACK;
                        phase_in          = i2c_seq_pkg::PH_WAIT_RX_ACK;
                     end else begin
                        rsp_in.bus_action = i2c_seq_pkg::ACT_RX_NACK;
                        phase_in          = i2c_seq_pkg::PH_WAIT_RX_NACK;
                     end
                  end
               end
               i2c_seq_pkg::PH_WAIT_RX_NACK: begin
                  rsp_in.read_valid = 1'b1;
                  rsp_in.read_byte  = in_item_ff.bus_read_byte;
                  rsp_in.bus_action = i2c_seq_pkg::ACT_STOP;
                  rsp_in.done_res   = 1'b1;
                  rsp_in.failed     = (status_m != i2c_seq_pkg::ST_MR_DATA_NACK);
                  phase_in          = i2c_seq_pkg::PH_IDLE;
               end
               default: begin
                  // idle or waiting for a write byte: ignored
               end
            endcase
         end
         default: begin
            // unused command: ignored
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         phase_ff       <= i2c_seq_pkg::PH_IDLE;
         addr_hi_ff     <= 4'd0;
         read_wanted_ff <= 1'b0;
         to_send_ff     <= 8'd0;
         to_read_ff     <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            phase_ff       <= phase_in;
            addr_hi_ff     <= addr_hi_in;
            read_wanted_ff <= read_wanted_in;
            to_send_ff     <= to_send_in;
            to_read_ff     <= to_read_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   // checks
   a_done_is_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.bus_action == i2c_seq_pkg::ACT_STOP)
      else $error("done without stop action");

   a_fail_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.failed |-> rsp_data.done_res)
      else $error("failure flagged without done");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_in.done_res |=> phase_ff == i2c_seq_pkg::PH_IDLE)
      else $error("phase not idle after stop");

   a_need_data_phase: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_in.need_data |=> phase_ff == i2c_seq_pkg::PH_WANT_DATA)
      else $error("write byte requested outside want-data phase");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("request stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== tb/sv/i2c_seq_checker.sv =====
// Checker for the I2C sequencer: predicts each response item and compares it on arrival.
`timescale 1ns / 1ps

module i2c_seq_checker
   import i2c_seq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatches,
   output int      outstanding
);

   // address byte keeps the top nibble only; bit 0 selects read
   localparam logic [7:0] ADDR_KEEP = 8'hF0;
   localparam logic [7:0] READ_BIT  = 8'h01;
   localparam int         MAX_LINES = 100;

   // predicted sequencer state
   phase_type  seq_phase;
   logic [7:0] dev_addr;
   logic       read_after;
   logic [7:0] writes_left;
   logic [7:0] reads_left;

   rsp_type    expected_actions[$];
   rsp_type    want;
   int         rsp_index;

   // stop ends the transaction, good or bad
   function rsp_type close_out(input rsp_type act, input logic fail);
      act.bus_action = ACT_STOP;
      act.done_res   = 1'b1;
      act.failed     = fail;
      seq_phase      = PH_IDLE;
      return act;
   endfunction

   // after an acked address or data byte: fetch more, turn round, or stop
   function rsp_type want_or_turn(input rsp_type act);
      if (writes_left != 8'd0) begin
         act.need_data = 1'b1;
         seq_phase     = PH_WANT_DATA;
      end else if (read_after) begin
         act.bus_action = ACT_START;
         seq_phase      = PH_WAIT_REPSTART;
      end else begin
         act = close_out(act, 1'b0);
      end
      return act;
   endfunction

   // last byte is received with NACK, the rest with ACK
   function rsp_type start_receive(input rsp_type act);
      if (reads_left > 8'd1) begin
         act.bus_action = ACT_RX_ACK;
         seq_phase      = PH_WAIT_RX_ACK;
      end else begin
         act.bus_action = ACT_RX_NACK;
         seq_phase      = PH_WAIT_RX_NACK;
      end
      return act;
   endfunction

   // one response item per request item; out-of-phase items give all zero
   function rsp_type predict_action(input req_type item);
      rsp_type    act;
      logic [7:0] st;
      act = '0;
      st  = item.bus_status & STATUS_MASK;
      case (item.command)
         CMD_BEGIN: if (seq_phase == PH_IDLE) begin
            dev_addr       = item.target_address & ADDR_KEEP;
            read_after     = item.with_read;
            writes_left    = item.request_count;
            reads_left     = (item.response_count == 8'd0) ? 8'd1 : item.response_count;
            act.bus_action = ACT_START;
            seq_phase      = PH_WAIT_START;
         end
         CMD_WRITE: if (seq_phase == PH_WANT_DATA) begin
            act.bus_action = ACT_DATA;
            act.bus_byte   = item.write_byte;
            writes_left    = writes_left - 8'd1;
            seq_phase      = PH_WAIT_DATA;
         end
         CMD_STATUS: case (seq_phase)
            // status after the first start is not checked
            PH_WAIT_START: begin
               act.bus_action = ACT_ADDR;
               act.bus_byte   = dev_addr;
               seq_phase      = PH_WAIT_SLAW;
            end
            PH_WAIT_SLAW: begin
               if (st != ST_MT_SLA_ACK) act = close_out(act, 1'b1);
               else act = want_or_turn(act);
            end
            PH_WAIT_DATA: begin
               if (st != ST_MT_DATA_ACK) act = close_out(act, 1'b1);
               else act = want_or_turn(act);
            end
            PH_WAIT_REPSTART: begin
               if (st != ST_REP_START) begin
                  act = close_out(act, 1'b1);
               end else begin
                  act.bus_action = ACT_ADDR;
                  act.bus_byte   = dev_addr | READ_BIT;
                  seq_phase      = PH_WAIT_SLAR;
               end
            end
            PH_WAIT_SLAR: begin
               if (st != ST_MR_SLA_ACK) act = close_out(act, 1'b1);
               else act = start_receive(act);
            end
            // received byte is passed on even when the status is wrong
            PH_WAIT_RX_ACK: begin
               act.read_valid = 1'b1;
               act.read_byte  = item.bus_read_byte;
               if (st != ST_MR_DATA_ACK) begin
                  act = close_out(act, 1'b1);
               end else begin
                  reads_left = reads_left - 8'd1;
                  act        = start_receive(act);
               end
            end
            PH_WAIT_RX_NACK: begin
               act.read_valid = 1'b1;
               act.read_byte  = item.bus_read_byte;
               act            = close_out(act, st != ST_MR_DATA_NACK);
            end
            default: ;
         endcase
         default: ;
      endcase
      return act;
   endfunction

   task report(input string msg);
      mismatches = mismatches + 1;
      if (mismatches <= MAX_LINES)
         $display("checker: response item %0d: %s", rsp_index, msg);
   endtask

   task check_field(input string name, input logic [7:0] got, input logic [7:0] exp_val);
      if (got !== exp_val)
         report($sformatf("%s got %0h, expected %0h", name, got, exp_val));
   endtask

   // results are matched before the new request is predicted
   always @(posedge clock) begin
      if (reset) begin
         seq_phase   = PH_IDLE;
         dev_addr    = '0;
         read_after  = 1'b0;
         writes_left = '0;
         reads_left  = '0;
         mismatches  = 0;
         rsp_index   = 0;
         expected_actions.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_actions.size() == 0) begin
               report("item with none expected");
            end else begin
               want = expected_actions.pop_front();
               check_field("bus_action", rsp_data.bus_action, want.bus_action);
               check_field("bus_byte",   rsp_data.bus_byte,   want.bus_byte);
               check_field("need_data",  rsp_data.need_data,  want.need_data);
               check_field("read_valid", rsp_data.read_valid, want.read_valid);
               check_field("read_byte",  rsp_data.read_byte,  want.read_byte);
               check_field("done_res",   rsp_data.done_res,   want.done_res);
               check_field("failed",     rsp_data.failed,     want.failed);
            end
            rsp_index = rsp_index + 1;
         end
         if (req_valid && !req_stall)
            expected_actions.push_back(predict_action(req_data));
         outstanding <= expected_actions.size();
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the I2C sequencer: clock, reset, transaction stimulus and verdict.
`timescale 1ns / 1ps

module tb;
   import i2c_seq_pkg::*;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         NUM_ITEMS   = 400;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         NO_FAULT    = 1000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   int fails;
   int pending;
   int items_sent = 0;
   int cycles     = 0;
   int stall_left = 0;
   int stall_draw;
   bit quiet = 1'b0;
   bit noisy = 1'b0;

   i2c_master_write_read_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   i2c_seq_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mismatches  (fails),
      .outstanding (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("i2c_master_write_read_sequencer: mismatch");
         $finish;
      end
   end

   // response side: stalls of random length at random, none in quiet stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_stall) begin
         if (stall_left == 0) rsp_stall <= 1'b0;
         else stall_left <= stall_left - 1;
      end else if (!quiet && (rsp_valid || $urandom_range(0, 7) == 0)) begin
         stall_draw = $urandom_range(0, 5);
         if (stall_draw > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_draw - 1;
         end
      end
   end

   // every field random, then the command forced
   function automatic req_type random_item(input logic [1:0] cmd);
      logic [63:0] raw;
      req_type     item;
      raw          = {$urandom, $urandom};
      item         = raw[$bits(req_type)-1:0];
      item.command = cmd;
      return item;
   endfunction

   // status item whose masked code is or is not the one wanted
   function automatic req_type status_item(input logic [7:0] code, input bit good);
      req_type item;
      item = random_item(CMD_STATUS);
      if (good) begin
         item.bus_status = code | 8'($urandom_range(0, 7));
      end else begin
         do item.bus_status = 8'($urandom);
         while ((item.bus_status & STATUS_MASK) == code);
      end
      return item;
   endfunction

   // one item: random gap, then hold until taken
   task automatic send(input req_type item, input bit counted);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (counted) items_sent++;
   endtask

   // now and then an item that the current phase ignores
   task automatic maybe_junk(input logic [1:0] a, input logic [1:0] b, input logic [1:0] c);
      int pick;
      if (noisy && $urandom_range(0, 9) == 0) begin
         pick = $urandom_range(0, 2);
         send(random_item(pick == 0 ? a : (pick == 1 ? b : c)), 1'b0);
      end
   endtask

   // checked status step; a wrong code goes out when the fault count runs down
   task automatic status_step(input logic [7:0] code, inout int left, output bit broke);
      maybe_junk(CMD_BEGIN, CMD_WRITE, CMD_UNUSED);
      broke = (left == 0);
      left  = left - 1;
      send(status_item(code, !broke), 1'b1);
   endtask

   // a full transaction as the bus engine would report it
   task automatic transaction(input logic [7:0] addr, input logic rd, input logic [7:0] nw,
                              input logic [7:0] nr, input int fault_after);
      req_type item;
      bit      broke;
      int      left;
      int      reads;
      left                = fault_after;
      item                = random_item(CMD_BEGIN);
      item.target_address = addr;
      item.with_read      = rd;
      item.request_count  = nw;
      item.response_count = nr;
      send(item, 1'b1);
      // status after the first start is taken unchecked
      maybe_junk(CMD_BEGIN, CMD_WRITE, CMD_UNUSED);
      send(random_item(CMD_STATUS), 1'b1);
      status_step(ST_MT_SLA_ACK, left, broke);
      if (broke) return;
      for (int i = 0; i < nw; i++) begin
         maybe_junk(CMD_BEGIN, CMD_STATUS, CMD_UNUSED);
         send(random_item(CMD_WRITE), 1'b1);
         status_step(ST_MT_DATA_ACK, left, broke);
         if (broke) return;
      end
      if (!rd) return;
      status_step(ST_REP_START, left, broke);
      if (broke) return;
      status_step(ST_MR_SLA_ACK, left, broke);
      if (broke) return;
      reads = (nr == 8'd0) ? 1 : nr;
      for (int i = 1; i < reads; i++) begin
         status_step(ST_MR_DATA_ACK, left, broke);
         if (broke) return;
      end
      status_step(ST_MR_DATA_NACK, left, broke);
   endtask

   // stimulus and verdict
   initial begin
      logic [7:0] nw;
      logic [7:0] nr;
      int         left;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: items ignored while idle
      send(random_item(CMD_STATUS), 1'b0);
      send(random_item(CMD_WRITE), 1'b0);
      send(random_item(CMD_UNUSED), 1'b0);
      // write then read with a zero read count, full address byte
      transaction(8'hFF, 1'b1, 8'd1, 8'd0, NO_FAULT);
      // write only with no data bytes
      transaction(8'h00, 1'b0, 8'd0, 8'd0, NO_FAULT);
      // no data bytes, then reads; wrong status on the first receive
      transaction(8'hA5, 1'b1, 8'd0, 8'd2, 3);
      // largest counts, address not acknowledged
      transaction(8'h5A, 1'b1, 8'hFF, 8'hFF, 0);

      // random transactions, some broken, with noise and quiet stretches
      noisy = 1'b1;
      while (items_sent < NUM_ITEMS) begin
         quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) == 0)
            maybe_junk(CMD_STATUS, CMD_WRITE, CMD_UNUSED);
         nw   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
         nr   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
         left = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : NO_FAULT;
         if ((nw > 8'd6 || nr > 8'd6) && left > 8)
            left = $urandom_range(0, 8);
         transaction(8'($urandom), 1'($urandom), nw, nr, left);
      end

      // drain, then allow for the pipeline
      req_valid <= 1'b0;
      quiet = 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (fails == 0)
         $display("i2c_master_write_read_sequencer: match");
      else
         $display("i2c_master_write_read_sequencer: mismatch");
      $finish;
   end

endmodule
